>>> src/dsmsfd_pkg.sv
// Shared types and constants for the serial frame decoder.
`timescale 1ns / 1ps

package dsmsfd_pkg;

    // Item opcodes.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Register indexes on the configuration port (taken from paddr bit 2).
    localparam logic REG_MODE = 1'b0;
    localparam logic REG_GAP  = 1'b1;

    // Configuration port address width.
    localparam int ADDR_W = 3;

    // Register reset values.
    localparam logic        MODE_RESET      = 1'b1;
    localparam logic [15:0] GAP_LIMIT_RESET = 16'd5000;

    // Output value constants.
    localparam logic [10:0] BASE_VALUE   = 11'd988;
    localparam logic [10:0] CENTER_VALUE = 11'd1500;
    localparam logic [10:0] OUT_MAX      = 11'd2047;

    // Channel count in the low resolution mode.
    localparam logic [4:0] LOW_RES_CHANNELS = 5'd7;

    // One input item.
    typedef struct packed {
        logic        opcode;
        logic [7:0]  rx_byte;
        logic [31:0] time_us;
        logic [3:0]  channel_index;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [10:0] pulse_width_us;
        logic        frame_ready;
    } out_item_t;

    // Configuration register values.
    typedef struct packed {
        logic        high_resolution_mode;
        logic [15:0] gap_limit_us;
    } cfg_t;

    // Frame assembly status handed to the top level and the channel store.
    typedef struct packed {
        logic complete;
        logic data_seen;
        logic complete_after_byte;
    } frm_status_t;

endpackage

>>> src/dsmsfd_cfg_regs.sv
// Configuration registers behind an APB-style port.
`timescale 1ns / 1ps

module dsmsfd_cfg_regs
    import dsmsfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic        mode_reg;
    logic        mode_next;
    logic [15:0] gap_reg;
    logic [15:0] gap_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register write decode; unused data bits are dropped.
    always_comb
    begin
        mode_next = mode_reg;
        gap_next  = gap_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_MODE: mode_next = pwdata[0];
                REG_GAP:  gap_next  = pwdata[15:0];
                default:  mode_next = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RESET;
            gap_reg  <= GAP_LIMIT_RESET;
        end
        else
        begin
            mode_reg <= mode_next;
            gap_reg  <= gap_next;
        end
    end

    // Read back.
    always_comb
    begin
        case (paddr[2])
            REG_MODE: prdata = {31'b0, mode_reg};
            REG_GAP:  prdata = {16'b0, gap_reg};
            default:  prdata = '0;
        endcase
    end

    assign cfg.high_resolution_mode = mode_reg;
    assign cfg.gap_limit_us         = gap_reg;

endmodule

>>> src/dsmsfd_frame_buf.sv
// Frame assembly: byte position, gap restart, frame bytes and complete flag.
`timescale 1ns / 1ps

module dsmsfd_frame_buf
    import dsmsfd_pkg::*;
#(
    parameter int FRAME_LENGTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         byte_en,
    input  logic                         clear_complete,
    input  logic [7:0]                   rx_byte,
    input  logic [31:0]                  time_us,
    input  logic [15:0]                  gap_limit_us,
    output logic [FRAME_LENGTH-1:0][7:0] frame_bytes,
    output frm_status_t                  status
);

    localparam int POS_W = $clog2(FRAME_LENGTH);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);

    logic [FRAME_LENGTH-1:0][7:0] frame_reg;
    logic [POS_W-1:0]             pos_reg;
    logic [POS_W-1:0]             pos_next;
    logic [31:0]                  last_time_reg;
    logic [31:0]                  last_time_next;
    logic                         complete_reg;
    logic                         complete_next;
    logic                         seen_reg;
    logic                         seen_next;
    logic [31:0]                  gap;
    logic                         restart;
    logic [POS_W-1:0]             pos_eff;
    logic                         at_last;

    // Gap check wraps modulo 2^32 and restarts the frame when too long.
    assign gap     = time_us - last_time_reg;
    assign restart = gap > {16'b0, gap_limit_us};
    assign pos_eff = restart ? '0 : pos_reg;
    assign at_last = pos_eff == LAST_POS;

    // Next state for a byte item or a read that consumes the frame.
    always_comb
    begin
        pos_next       = pos_reg;
        last_time_next = last_time_reg;
        complete_next  = complete_reg;
        seen_next      = seen_reg;
        if (byte_en)
        begin
            seen_next      = 1'b1;
            last_time_next = time_us;
            if (at_last)
            begin
                pos_next      = pos_eff;
                complete_next = 1'b1;
            end
            else
            begin
                pos_next = pos_eff + POS_W'(1);
            end
        end
        else if (clear_complete)
        begin
            complete_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            last_time_reg <= '0;
            complete_reg  <= 1'b0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            last_time_reg <= last_time_next;
            complete_reg  <= complete_next;
            seen_reg      <= seen_next;
        end
    end

    // Frame bytes are payload and carry no reset.
    always_ff @(posedge clk)
    begin
        if (byte_en)
        begin
            frame_reg[pos_eff] <= rx_byte;
        end
    end

    assign frame_bytes                = frame_reg;
    assign status.complete            = complete_reg;
    assign status.data_seen           = seen_reg;
    assign status.complete_after_byte = complete_reg || at_last;

    // The flag only rises from a byte written at the last position.
    a_complete_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(complete_reg) |-> $past(byte_en) && $past(at_last))
        else $error("complete flag rose without a last-position byte");

    // The position never leaves the frame.
    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("frame position out of range");

endmodule

>>> src/dsmsfd_chan_store.sv
// Channel store: decodes a complete frame and returns a channel's pulse width.
`timescale 1ns / 1ps

module dsmsfd_chan_store
    import dsmsfd_pkg::*;
#(
    parameter int FRAME_LENGTH = 16,
    parameter int MAX_CHANNELS = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         decode_en,
    input  logic                         high_resolution_mode,
    input  logic                         data_seen,
    input  logic [FRAME_LENGTH-1:0][7:0] frame_bytes,
    input  logic [3:0]                   channel_index,
    output logic [10:0]                  pulse_width_us
);

    localparam int NPAIRS = (FRAME_LENGTH - 2) / 2;
    localparam int CH_W   = $clog2(MAX_CHANNELS);

    logic [MAX_CHANNELS-1:0][10:0] chan_reg;
    logic [MAX_CHANNELS-1:0][10:0] chan_next;
    logic [NPAIRS-1:0][3:0]        pair_id;
    logic [NPAIRS-1:0][10:0]       pair_val;
    logic [NPAIRS-1:0]             pair_ok;
    logic [4:0]                    chan_count;
    logic                          in_range;
    logic [10:0]                   value;
    logic [11:0]                   sum;

    assign chan_count = high_resolution_mode ? 5'(MAX_CHANNELS) : LOW_RES_CHANNELS;

    // Split each byte pair into a channel id and a value.
    always_comb
    begin
        for (int p = 0; p < NPAIRS; p++)
        begin
            if (high_resolution_mode)
            begin
                pair_id[p]  = frame_bytes[2*p+2][6:3];
                pair_val[p] = {frame_bytes[2*p+2][2:0], frame_bytes[2*p+3]};
            end
            else
            begin
                pair_id[p]  = frame_bytes[2*p+2][5:2];
                pair_val[p] = {1'b0, frame_bytes[2*p+2][1:0], frame_bytes[2*p+3]};
            end
            pair_ok[p] = {1'b0, pair_id[p]} < chan_count;
        end
    end

    // Later pairs override earlier ones for the same channel.
    always_comb
    begin
        chan_next = chan_reg;
        if (decode_en)
        begin
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                for (int p = 0; p < NPAIRS; p++)
                begin
                    if (pair_ok[p] && pair_id[p] == 4'(c))
                    begin
                        chan_next[c] = pair_val[p];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= '0;
        end
        else
        begin
            chan_reg <= chan_next;
        end
    end

    // Read the freshly decoded value and scale it to microseconds.
    assign in_range = {1'b0, channel_index} < chan_count;
    assign value    = chan_next[channel_index[CH_W-1:0]];
    assign sum      = {1'b0, BASE_VALUE}
                    + (high_resolution_mode ? {2'b0, value[10:1]} : {1'b0, value});

    always_comb
    begin
        if (!in_range || !data_seen)
        begin
            pulse_width_us = CENTER_VALUE;
        end
        else if (sum > {1'b0, OUT_MAX})
        begin
            pulse_width_us = OUT_MAX;
        end
        else
        begin
            pulse_width_us = sum[10:0];
        end
    end

endmodule

>>> src/dsm_serial_frame_decoder.sv
// Top level of the serial frame decoder: input stage, result register, submodules.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_ready   in_item  (in_item_t)
//   out      output     out_valid / out_ready out_item (out_item_t)
//   cfg      input      APB psel/penable      paddr, pwdata, prdata
//
// An item is registered in the input register on acceptance, processed once the
// output can advance, and its result is registered in the result register; one
// item per cycle is sustained while the output is not stalled. All frame and
// channel work sits between these registers. Reset clears the position,
// timestamp, flags, the channel store and both valid bits. A stalled output holds
// the result while the input register still takes one more item.
`timescale 1ns / 1ps

module dsm_serial_frame_decoder
    import dsmsfd_pkg::*;
#(
    parameter int FRAME_LENGTH = 16,
    parameter int MAX_CHANNELS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t                         cfg;
    frm_status_t                  status;
    logic [FRAME_LENGTH-1:0][7:0] frame_bytes;
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    in_item_t                     s1_item_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    out_item_t                    out_item_reg;
    out_item_t                    result;
    logic                         advance;
    logic                         fire;
    logic                         is_read;
    logic                         byte_en;
    logic                         decode_en;
    logic [10:0]                  read_value;

    // Handshake control for the two register stages.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign fire     = s1_valid_reg && advance;
    assign is_read  = s1_item_reg.opcode == OP_READ;
    assign byte_en  = fire && !is_read;
    assign decode_en = fire && is_read && status.complete;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_item;
        end
        if (fire)
        begin
            out_item_reg <= result;
        end
    end

    dsmsfd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dsmsfd_frame_buf #(
        .FRAME_LENGTH (FRAME_LENGTH)
    ) u_frame (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_en        (byte_en),
        .clear_complete (decode_en),
        .rx_byte        (s1_item_reg.rx_byte),
        .time_us        (s1_item_reg.time_us),
        .gap_limit_us   (cfg.gap_limit_us),
        .frame_bytes    (frame_bytes),
        .status         (status)
    );

    dsmsfd_chan_store #(
        .FRAME_LENGTH (FRAME_LENGTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_chan (
        .clk                  (clk),
        .rst_n                (rst_n),
        .decode_en            (decode_en),
        .high_resolution_mode (cfg.high_resolution_mode),
        .data_seen            (status.data_seen),
        .frame_bytes          (frame_bytes),
        .channel_index        (s1_item_reg.channel_index),
        .pulse_width_us       (read_value)
    );

    // A read always leaves the flag clear; a byte item reports the updated flag.
    assign result.pulse_width_us = is_read ? read_value : 11'd0;
    assign result.frame_ready    = is_read ? 1'b0 : status.complete_after_byte;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // A byte item yields a zero pulse width.
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        byte_en |=> out_item_reg.pulse_width_us == 11'd0)
        else $error("byte item produced a nonzero pulse width");

    // A read item always reports the flag clear.
    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_read |=> !out_item_reg.frame_ready && !status.complete)
        else $error("read item left the complete flag set");

    // Input is only held off when both stages are full and the output stalls.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a full pipeline");

endmodule

>>> bench/dsm_serial_frame_decoder_tb.sv
// Self-checking testbench for the serial frame decoder: directed cases, then random frame traffic.
`timescale 1ns / 1ps

module dsm_serial_frame_decoder_tb;
    import dsmsfd_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    in_item_t          in_item;
    logic              out_valid;
    logic              out_ready;
    out_item_t         out_item;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    dsm_serial_frame_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Shadow copy of the decoder state.
    logic [7:0]  frame_img [16];
    int          frame_pos;
    logic [31:0] prev_byte_time;
    logic        frame_full;
    logic        byte_seen;
    logic [10:0] chan_store [8];
    logic        hires;
    logic [15:0] gap_lim;

    // Expected results, oldest first, and run bookkeeping.
    out_item_t   expected_readings [$];
    int          mismatches;
    int          items_sent;
    logic [31:0] stim_clock;
    bit          pauses_on;
    int          stall_left;

    // 10 ns clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic void clear_shadow();
        for (int i = 0; i < 16; i++)
            frame_img[i] = 8'h00;
        for (int i = 0; i < 8; i++)
            chan_store[i] = 11'd0;
        frame_pos      = 0;
        prev_byte_time = 32'd0;
        frame_full     = 1'b0;
        byte_seen      = 1'b0;
        hires          = MODE_RESET;
        gap_lim        = GAP_LIMIT_RESET;
    endfunction

    // Applies one accepted item to the shadow state and returns its result.
    function automatic out_item_t decode_step(input in_item_t it);
        out_item_t   r;
        logic [31:0] gap;
        logic [11:0] sum;
        logic [7:0]  hi;
        logic [7:0]  lo;
        int          n_chan;
        int          id;
        r.pulse_width_us = 11'd0;
        if (it.opcode == OP_BYTE)
        begin
            gap            = it.time_us - prev_byte_time;
            byte_seen      = 1'b1;
            prev_byte_time = it.time_us;
            if (gap > {16'd0, gap_lim})
                frame_pos = 0;
            frame_img[frame_pos] = it.rx_byte;
            if (frame_pos == 15)
                frame_full = 1'b1;
            else
                frame_pos++;
        end
        else
        begin
            n_chan = hires ? 8 : int'(LOW_RES_CHANNELS);
            // A pending frame is decoded pair by pair; later pairs win.
            if (frame_full)
            begin
                for (int k = 3; k < 16; k += 2)
                begin
                    hi = frame_img[k-1];
                    lo = frame_img[k];
                    id = hires ? int'(hi[6:3]) : int'(hi[5:2]);
                    if (id < n_chan)
                        chan_store[id] = hires ? {hi[2:0], lo} : {1'b0, hi[1:0], lo};
                end
                frame_full = 1'b0;
            end
            if (int'(it.channel_index) >= n_chan || !byte_seen)
                r.pulse_width_us = CENTER_VALUE;
            else
            begin
                if (hires)
                    sum = {1'b0, BASE_VALUE} + {2'b0, chan_store[it.channel_index][10:1]};
                else
                    sum = {1'b0, BASE_VALUE} + {1'b0, chan_store[it.channel_index]};
                // A value decoded in 2048 mode and read in 1024 mode can overflow.
                r.pulse_width_us = (sum > {1'b0, OUT_MAX}) ? OUT_MAX : sum[10:0];
            end
        end
        r.frame_ready = frame_full;
        return r;
    endfunction

    // Result check first, then prediction of the item accepted at this edge.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_readings.size() == 0)
                    report_mismatch($sformatf("result %0d/%0b with none expected",
                                              out_item.pulse_width_us, out_item.frame_ready));
                else
                begin
                    want = expected_readings.pop_front();
                    if (out_item.pulse_width_us !== want.pulse_width_us)
                        report_mismatch($sformatf("pulse_width_us %0d, expected %0d",
                                                  out_item.pulse_width_us, want.pulse_width_us));
                    if (out_item.frame_ready !== want.frame_ready)
                        report_mismatch($sformatf("frame_ready %0b, expected %0b",
                                                  out_item.frame_ready, want.frame_ready));
                end
            end
            if (in_valid && in_ready)
                expected_readings.push_back(decode_step(in_item));
        end
    end

    // Output back-pressure in random bursts.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (pauses_on && $urandom_range(0, 5) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end
        else
            out_ready <= 1'b1;
    end

    // Offers one item, with an occasional gap before it, and waits for acceptance.
    task automatic offer_item(input in_item_t it);
        if (pauses_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] value, input logic [31:0] stamp);
        in_item_t it;
        it.opcode        = OP_BYTE;
        it.rx_byte       = value;
        it.time_us       = stamp;
        it.channel_index = 4'($urandom);
        stim_clock       = stamp;
        offer_item(it);
    endtask

    task automatic send_read(input logic [3:0] chan);
        in_item_t it;
        it.opcode        = OP_READ;
        it.rx_byte       = 8'($urandom);
        it.time_us       = $urandom;
        it.channel_index = chan;
        offer_item(it);
    endtask

    // Lowers valid and waits until every expected result has come back. The
    // first edge lets the checker record an item accepted at the current edge.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_readings.size() != 0)
            @(posedge clk);
    endtask

    // One write with a setup and an access phase, then the bus returns to idle.
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Writes both registers while idle; the unused upper bits carry noise.
    task automatic set_config(input logic mode, input logic [15:0] gap);
        logic [31:0] word;
        wait_drained();
        word    = $urandom;
        word[0] = mode;
        write_reg({REG_MODE, 2'b00}, word);
        hires   = mode;
        word    = $urandom;
        word[15:0] = gap;
        write_reg({REG_GAP, 2'b00}, word);
        gap_lim = gap;
    endtask

    // Sends n bytes of a frame: the first one restarts it, the rest stay within
    // the gap limit. Reads are sprinkled in and follow at the end.
    task automatic send_frame(input int n_bytes);
        logic [7:0]  b;
        logic [31:0] step;
        for (int k = 0; k < n_bytes; k++)
        begin
            if (k > 0 && $urandom_range(0, 7) == 0)
                send_read(4'($urandom_range(0, 15)));
            b = 8'($urandom);
            // Steer most high bytes of the pairs to a channel that exists.
            if (k >= 2 && k % 2 == 0 && $urandom_range(0, 3) != 0)
            begin
                if (hires)
                    b[6:3] = 4'($urandom_range(0, 7));
                else
                    b[5:2] = 4'($urandom_range(0, 6));
            end
            if (k == 0)
                step = {16'd0, gap_lim} + 32'd1 + $urandom_range(0, 100000);
            else if ($urandom_range(0, 3) == 0)
                step = {16'd0, gap_lim};
            else
                step = $urandom_range(0, gap_lim);
            send_byte(b, stim_clock + step);
        end
        repeat ($urandom_range(1, 3)) send_read(4'($urandom_range(0, 15)));
    endtask

    // Before any byte every channel reads as center.
    task automatic test_reads_before_data();
        send_read(4'd0);
        send_read(4'd15);
    endtask

    // A full frame with extreme bytes, a timestamp wrap and a gap exactly at the
    // limit, then one byte past the end, then reads that force the decode.
    task automatic test_frame_decode();
        logic [7:0]  img [16] = '{8'h00, 8'hFF, 8'h07, 8'hFF, 8'h38, 8'h00, 8'hFF, 8'hAA,
                                 8'h40, 8'h55, 8'h0D, 8'h12, 8'h0A, 8'h34, 8'h17, 8'h80};
        logic [31:0] stamp;
        stamp = 32'hFFFF_FFF8;
        for (int k = 0; k < 16; k++)
        begin
            send_byte(img[k], stamp);
            stamp = (k == 3) ? stamp + {16'd0, gap_lim} : stamp + 32'd1;
        end
        // The flag is set, so this byte overwrites the last position.
        send_byte(8'h01, stamp);
        send_read(4'd0);
        send_read(4'd1);
        send_read(4'd7);
        send_read(4'd8);
    endtask

    // Values decoded in 2048 mode, read back in 1024 mode.
    task automatic test_mode_saturation();
        set_config(1'b0, gap_lim);
        send_read(4'd0);
        send_read(4'd7);
    endtask

    task automatic test_random_traffic(input logic mode, input logic [15:0] gap,
                                       input bit pauses, input int n_items);
        int stop_at;
        int pick;
        set_config(mode, gap);
        pauses_on = pauses;
        stop_at   = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 13)
                send_frame(16);
            else if (pick < 15)
                send_frame($urandom_range(1, 15));
            else if (pick < 17)
                send_byte(8'($urandom), stim_clock + $urandom_range(0, gap));
            else if (pick < 18)
                send_byte(8'($urandom), $urandom);
            else
                send_read(4'($urandom_range(0, 15)));
        end
    endtask

    // Main sequence.
    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_item    <= '0;
        out_ready  <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= 32'd0;
        stall_left = 0;
        mismatches = 0;
        items_sent = 0;
        stim_clock = 32'd0;
        pauses_on  = 1'b1;
        clear_shadow();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reads_before_data();
        test_frame_decode();
        test_mode_saturation();
        test_random_traffic(1'b1, 16'd5000, 1'b1, 110);
        test_random_traffic(1'b0, 16'd65535, 1'b1, 110);
        test_random_traffic(1'b1, 16'd0, 1'b1, 110);
        test_random_traffic(1'b0, 16'($urandom_range(1, 2000)), 1'b1, 110);
        test_random_traffic(1'b1, 16'($urandom), 1'b0, 110);

        // Drain, then allow the pipeline to empty.
        in_valid <= 1'b0;
        for (int c = 0; c < 2000 && expected_readings.size() != 0; c++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (expected_readings.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_readings.size()));
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
